/* src/holt_trend_filter_cascade_macros.svh */
// Assertion macros for the Holt trend filter cascade.
// Each macro samples on the rising edge of clock and is off during reset.
`ifndef HOLT_TREND_FILTER_CASCADE_MACROS_SVH
`define HOLT_TREND_FILTER_CASCADE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HTF_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("htf: same-cycle check failed");
`define HTF_ASSERT_NXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("htf: next-cycle check failed");
`else
`define HTF_ASSERT_IMP(name, pre, post)
`define HTF_ASSERT_NXT(name, pre, post)
`endif
`endif

/* src/htf_pkg.sv */
package htf_pkg;

   // cascade depth is fixed
   localparam int STAGES = 4;
   localparam logic [1:0] LAST_K = 2'(STAGES - 1);

   // transaction payloads
   typedef struct packed {
      logic signed [23:0] sample_in;
      logic [3:0]         channel;
   } req_type;

   typedef struct packed {
      logic signed [23:0] sample_out;
      logic [3:0]         channel_out;
   } rsp_type;

   // register indexes
   localparam logic [1:0] CSR_FREQUENCY = 2'd0;
   localparam logic [1:0] CSR_RESONANCE = 2'd1;
   localparam logic [1:0] CSR_POLES     = 2'd2;

   localparam logic [15:0] FREQUENCY_RST = 16'd64880;
   localparam logic [15:0] RESONANCE_RST = 16'd655;
   localparam logic [15:0] POLES_RST     = 16'd64880;

   // fixed-point constants
   localparam logic [17:0]        ONE17   = 18'd131072;
   localparam logic [18:0]        EPS17   = 19'd1;
   localparam logic signed [18:0] K999    = 19'sd130941;
   localparam logic [32:0]        CLIPQ32 = 33'd5382943231;
   localparam logic [16:0]        UNITY_W = 17'd65536;
   localparam logic [30:0]        G_ONE   = 31'd1073741824;
   localparam logic [2:0]         HORNER_TOP = 3'd4;

   // sin(s)/s polynomial in s^2, Q4.30
   localparam logic signed [33:0] GCOEF [6] = '{
      34'sd1073741824, -34'sd178956971, 34'sd8947849,
      -34'sd213044, 34'sd2959, -34'sd27
   };

   typedef enum logic [4:0] {
      S_DSQ, S_DCUBE, S_DQUAD, S_DA0, S_DBM, S_DB, S_DAM, S_DA,
      ST_IDLE, ST_RD,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
      SA_ABS, SA_SQ, SA_S, SA_S2M, SA_S2, SA_HM, SA_HA, SA_FM, SA_FIN,
      ST_OUT
   } htf_state_type;

   // crossfade weight of stage k for dv = poles*4, Q1.16
   function automatic logic [16:0] stage_weight(input logic [17:0] dv, input logic [1:0] k);
      logic [18:0] lo;
      logic [18:0] hi;
      logic [16:0] w;
      lo = {1'b0, k, 16'd0};
      hi = lo + 19'd65536;
      if ({1'b0, dv} <= lo) begin
         w = '0;
      end else if (k != LAST_K && {1'b0, dv} >= hi) begin
         w = UNITY_W;
      end else begin
         w = 17'({1'b0, dv} - lo);
      end
      return w;
   endfunction

endpackage

/* src/holt_trend_filter_cascade.sv */
// Holt level-and-trend filter cascade: each transaction on req_ carries a
// signed Q3.21 sample and a channel number; up to four smoothing stages run in
// turn on that voice's level and trend (kept in two on-chip memories,
// channel modulo VOICES selects the voice), then the value is clipped and
// shaped by sin(x|x|)/|x|. One item is in work at a time, one result per item.
// Per active stage an item passes one memory read, six products through one
// shared 19x42 multiplier and one write back; the saturator then runs its
// sine polynomial through a 34x34 multiplier one term at a time, and the
// output register is loaded. Every stage turned off by the poles register is
// skipped. A finished result waits in the output register while the next
// item is taken. A write to frequency or resonance recomputes alpha and
// beta, also right after reset, during which no transaction is taken.
`include "holt_trend_filter_cascade_macros.svh"

module holt_trend_filter_cascade import htf_pkg::*; #(
   parameter int VOICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int DEPTH  = VOICES * STAGES;
   localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int ADDR_W = $clog2(DEPTH);

   htf_state_type state_ff, state_in;

   // configuration and coefficients
   logic [15:0] frequency_ff, resonance_ff, poles_ff;
   logic [31:0] f2_ff, r2_ff;
   logic [47:0] f3_ff;
   logic [63:0] dprod_ff;
   logic [17:0] a0_ff, b_ff, alpha_ff, beta_ff;
   logic [18:0] a0_t, b_t, a_t;

   // item registers
   logic [3:0]          ch_ff;
   logic [VIDX_W-1:0]   voice_ff;
   logic [1:0]          k_ff;
   logic signed [41:0]  x_ff, other_ff;
   logic signed [39:0]  y_ff, tr_ff;
   logic signed [60:0]  prod_ff;
   logic signed [61:0]  acc_ff, sum;
   logic signed [39:0]  lvl_rd_ff, trd_rd_ff, lvl, trd;
   logic                vld_rd_ff;

   // saturator registers
   logic                neg_ff;
   logic [30:0]         a30_ff, s_ff, gcl;
   logic [31:0]         s2_ff;
   logic signed [33:0]  g_ff;
   logic [2:0]          j_ff;
   logic signed [67:0]  smul_ff;
   logic signed [33:0]  sat_a, sat_b;
   logic signed [41:0]  ax;
   logic [32:0]         clipped;
   logic [23:0]         res_mag;

   // memories
   logic [39:0]       level_mem [DEPTH];
   logic [39:0]       trend_mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [ADDR_W-1:0] addr;
   logic              mem_rd, mem_we, rsp_load;

   logic signed [18:0] mul_a;
   logic signed [41:0] mul_b;
   logic [17:0]        dv;
   logic [16:0]        w_cur, w_nxt, w_first;
   logic signed [39:0] y_sat, tr_sat;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic [VIDX_W-1:0]  voice_lut [16];
   logic               coef_wr;

   // voice of each channel number
   for (genvar g = 0; g < 16; g++) begin : g_voice
      assign voice_lut[g] = VIDX_W'(g % VOICES);
   end

   function automatic logic signed [39:0] sat40(input logic signed [44:0] v);
      logic signed [39:0] r;
      if (v[44:39] == {6{v[44]}}) begin
         r = v[39:0];
      end else if (v[44]) begin
         r = {1'b1, 39'd0};
      end else begin
         r = {1'b0, {39{1'b1}}};
      end
      return r;
   endfunction

   assign dv      = {poles_ff, 2'b00};
   assign w_cur   = stage_weight(dv, k_ff);
   assign w_nxt   = stage_weight(dv, k_ff + 2'd1);
   assign w_first = stage_weight(dv, 2'd0);
   assign addr    = ADDR_W'({voice_ff, k_ff});
   assign lvl     = vld_rd_ff ? lvl_rd_ff : '0;
   assign trd     = vld_rd_ff ? trd_rd_ff : '0;
   assign sum     = acc_ff + {prod_ff[60], prod_ff};
   assign tr_sat  = sat40(sum[61:17]);
   assign y_sat   = sat40(sum[61:17]);

   // coefficient clamps
   assign a0_t = 19'(dprod_ff[63:47]) + EPS17;
   assign b_t  = dprod_ff[50:32] + EPS17;
   assign a_t  = {1'b0, a0_ff} + {1'b0, dprod_ff[49:32]};

   // shared stage multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M1: begin
            mul_a = {1'b0, beta_ff};
            mul_b = x_ff - {{2{lvl[39]}}, lvl};
         end
         ST_M2: begin
            mul_a = K999 - {1'b0, beta_ff};
            mul_b = {{2{trd[39]}}, trd};
         end
         ST_M3: begin
            mul_a = {1'b0, alpha_ff};
            mul_b = x_ff;
         end
         ST_M4: begin
            mul_a = K999 - {1'b0, alpha_ff};
            mul_b = {{2{lvl[39]}}, lvl} + {{2{trd[39]}}, trd};
         end
         ST_M6: begin
            mul_a = {2'b00, w_cur};
            mul_b = {{2{y_ff[39]}}, y_ff};
         end
         ST_M7: begin
            mul_a = {2'b00, UNITY_W - w_cur};
            mul_b = other_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // saturator operands and clamps
   assign ax      = x_ff[41] ? -x_ff : x_ff;
   assign clipped = (ax > {9'd0, CLIPQ32}) ? CLIPQ32 : ax[32:0];
   assign gcl     = g_ff[33] ? '0 : ((g_ff > {3'd0, G_ONE}) ? G_ONE : g_ff[30:0]);
   assign res_mag = smul_ff[62:39];

   always_comb begin
      sat_a = '0;
      sat_b = '0;
      case (state_ff)
         SA_SQ: begin
            sat_a = {3'd0, a30_ff};
            sat_b = {3'd0, a30_ff};
         end
         SA_S2M: begin
            sat_a = {3'd0, s_ff};
            sat_b = {3'd0, s_ff};
         end
         SA_HM: begin
            sat_a = g_ff;
            sat_b = {2'd0, s2_ff};
         end
         SA_FM: begin
            sat_a = {3'd0, a30_ff};
            sat_b = {3'd0, gcl};
         end
         default: begin
            sat_a = '0;
            sat_b = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_DSQ;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      mem_rd    = 1'b0;
      mem_we    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_DSQ:   state_in = S_DCUBE;
         S_DCUBE: state_in = S_DQUAD;
         S_DQUAD: state_in = S_DA0;
         S_DA0:   state_in = S_DBM;
         S_DBM:   state_in = S_DB;
         S_DB:    state_in = S_DAM;
         S_DAM:   state_in = S_DA;
         S_DA:    state_in = ST_IDLE;
         ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            if (csr_valid) begin
               if (csr_index == CSR_FREQUENCY || csr_index == CSR_RESONANCE) begin
                  state_in = S_DSQ;
               end
            end else if (req_valid) begin
               state_in = (w_first == '0) ? SA_ABS : ST_RD;
            end
         end
         ST_RD: begin
            mem_rd   = 1'b1;
            state_in = ST_M1;
         end
         ST_M1: state_in = ST_M2;
         ST_M2: state_in = ST_M3;
         ST_M3: state_in = ST_M4;
         ST_M4: state_in = ST_M5;
         ST_M5: begin
            mem_we   = 1'b1;
            state_in = ST_M6;
         end
         ST_M6: state_in = ST_M7;
         ST_M7: state_in = ST_M8;
         ST_M8: begin
            if (k_ff == LAST_K || w_nxt == '0) begin
               state_in = SA_ABS;
            end else begin
               state_in = ST_RD;
            end
         end
         SA_ABS: state_in = SA_SQ;
         SA_SQ:  state_in = SA_S;
         SA_S:   state_in = SA_S2M;
         SA_S2M: state_in = SA_S2;
         SA_S2:  state_in = SA_HM;
         SA_HM:  state_in = SA_HA;
         SA_HA:  state_in = (j_ff == '0) ? SA_FM : SA_HM;
         SA_FM:  state_in = SA_FIN;
         SA_FIN: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frequency_ff <= FREQUENCY_RST;
         resonance_ff <= RESONANCE_RST;
         poles_ff     <= POLES_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FREQUENCY: frequency_ff <= csr_data;
            CSR_RESONANCE: resonance_ff <= csr_data;
            CSR_POLES:     poles_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // coefficient derivation
   always_ff @(posedge clock) begin
      case (state_ff)
         S_DSQ: begin
            f2_ff <= 32'(frequency_ff) * 32'(frequency_ff);
            r2_ff <= 32'(resonance_ff) * 32'(resonance_ff);
         end
         S_DCUBE: f3_ff    <= 48'(f2_ff) * 48'(frequency_ff);
         S_DQUAD: dprod_ff <= 64'(f3_ff) * 64'(frequency_ff);
         S_DA0:   a0_ff    <= (a0_t > {1'b0, ONE17}) ? ONE17 : a0_t[17:0];
         S_DBM:   dprod_ff <= 64'(a0_ff) * 64'(r2_ff);
         S_DB:    b_ff     <= (b_t > {1'b0, ONE17}) ? ONE17 : b_t[17:0];
         S_DAM:   dprod_ff <= 64'(ONE17 - b_ff) * 64'(f3_ff[47:16]);
         S_DA: begin
            alpha_ff <= (a_t > {1'b0, ONE17}) ? ONE17 : a_t[17:0];
            beta_ff  <= b_ff;
         end
         default: ;
      endcase
   end

   // stage datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      // final saturator product is held until the output register takes it
      if (state_ff != SA_FIN && state_ff != ST_OUT) begin
         smul_ff <= sat_a * sat_b;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               x_ff     <= {{7{req_data.sample_in[23]}}, req_data.sample_in, 11'd0};
               other_ff <= {{7{req_data.sample_in[23]}}, req_data.sample_in, 11'd0};
               ch_ff    <= req_data.channel;
               voice_ff <= voice_lut[req_data.channel];
               k_ff     <= '0;
            end
         end
         ST_M2: acc_ff <= {prod_ff[60], prod_ff};
         ST_M3: tr_ff  <= tr_sat;
         ST_M4: acc_ff <= {prod_ff[60], prod_ff};
         ST_M5: y_ff   <= y_sat;
         ST_M7: acc_ff <= {prod_ff[60], prod_ff};
         ST_M8: begin
            x_ff     <= sum[57:16];
            other_ff <= {{2{y_ff[39]}}, y_ff};
            k_ff     <= k_ff + 2'd1;
         end
         SA_ABS: begin
            neg_ff <= x_ff[41];
            a30_ff <= clipped[32:2];
         end
         SA_S: s_ff <= smul_ff[60:30];
         SA_S2: begin
            s2_ff <= smul_ff[61:30];
            g_ff  <= GCOEF[5];
            j_ff  <= HORNER_TOP;
         end
         SA_HA: begin
            g_ff <= GCOEF[j_ff] + 34'(smul_ff >>> 30);
            j_ff <= j_ff - 3'd1;
         end
         default: ;
      endcase
   end

   // level and trend memories
   always_ff @(posedge clock) begin
      if (mem_rd) begin
         lvl_rd_ff <= level_mem[addr];
         trd_rd_ff <= trend_mem[addr];
      end
      if (mem_we) begin
         level_mem[addr] <= y_sat;
         trend_mem[addr] <= tr_ff;
      end
   end

   // entry valid bits, an unwritten entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (mem_rd) begin
            vld_rd_ff <= valid_ff[addr];
         end
         if (mem_we) begin
            valid_ff[addr] <= 1'b1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.sample_out  <= neg_ff ? -res_mag : res_mag;
         rsp_data_ff.channel_out <= ch_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // coefficient register write
   assign coef_wr = csr_valid && csr_ready &&
                    (csr_index == CSR_FREQUENCY || csr_index == CSR_RESONANCE);

   `HTF_ASSERT_NXT(a_accept_busy, req_valid && req_ready, state_ff != ST_IDLE)
   `HTF_ASSERT_NXT(a_coef_rederive, coef_wr, state_ff == S_DSQ)
   `HTF_ASSERT_IMP(a_coef_range, state_ff == ST_IDLE, alpha_ff <= ONE17 && beta_ff <= ONE17)

endmodule
